>>> hw/rtl/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared constants and helpers for the epoch to civil date and time pipeline.
// ----------------------------------------------------------------------------
package e2c_pkg;

   localparam int NUM_STAGES = 8;

   localparam int EPOCH_W = 32;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DOM_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   localparam int DAY_W   = 16;
   localparam int SOD_W   = 17;
   localparam int IC_W    = 18;
   localparam int YOE_W   = 9;
   localparam int DOY_W   = 9;
   localparam int MP_W    = 4;

   // Reciprocal constants for exact floor division over the given input ranges.
   localparam logic [25:0] RCP_DAY   = 26'd50903317;
   localparam int          SH_DAY    = 35;
   localparam logic [13:0] RCP_HOUR  = 14'd9321;
   localparam int          SH_HOUR   = 21;
   localparam logic [10:0] RCP_MIN   = 11'd1093;
   localparam int          SH_MIN    = 14;
   localparam logic [16:0] RCP_QUAD  = 17'd91930;
   localparam int          SH_QUAD   = 25;
   localparam logic [18:0] RCP_YEAR  = 19'd367720;
   localparam int          SH_YEAR   = 27;
   localparam logic [11:0] RCP_MONTH = 12'd3427;
   localparam int          SH_MONTH  = 19;

   localparam logic [19:0] SHIFT_TO_MARCH0 = 20'd719468;
   localparam logic [19:0] FOUR_CYCLES     = 20'd584388;
   localparam logic [19:0] FIVE_CYCLES     = 20'd730485;
   localparam logic [17:0] CENTURY_1       = 18'd36524;
   localparam logic [17:0] CENTURY_2       = 18'd73048;
   localparam logic [17:0] CENTURY_3       = 18'd109572;
   localparam logic [17:0] LAST_DAY_CYCLE  = 18'd146096;

   // First day of each month counted from March 1.
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/e2c_front.sv
// ----------------------------------------------------------------------------
// e2c_front
// First two stages: day number, its seconds product and the day within the
// 400-year cycle counted from March 1.
// ----------------------------------------------------------------------------
module e2c_front
   import e2c_pkg::*;
(
   input  logic               clock,
   input  logic [1:0]         en,
   input  logic [EPOCH_W-1:0] epoch_seconds,
   output logic [EPOCH_W-1:0] t_s2,
   output logic [EPOCH_W-1:0] day_secs_s2,
   output logic [IC_W-1:0]    ic_s2,
   output logic               cyc_hi_s2
);

   logic [EPOCH_W-1:0] t_s1_ff, t_s1_in;
   logic [50:0]        pday_ff, pday_in;

   logic [EPOCH_W-1:0] t_s2_ff, t_s2_in;
   logic [EPOCH_W-1:0] dsec_ff, dsec_in;
   logic [IC_W-1:0]    ic_ff, ic_in;
   logic               cyc_hi_ff, cyc_hi_in;

   logic [DAY_W-1:0]   day;
   logic [19:0]        shifted;

   always_comb begin
      t_s1_in = epoch_seconds;
      pday_in = 51'(epoch_seconds[31:7]) * 51'(RCP_DAY);
   end

   always_comb begin
      day       = DAY_W'(pday_ff >> SH_DAY);
      t_s2_in   = t_s1_ff;
      dsec_in   = EPOCH_W'(EPOCH_W'(day) * EPOCH_W'(86400));
      shifted   = 20'(day) + SHIFT_TO_MARCH0;
      cyc_hi_in = (shifted >= FIVE_CYCLES);
      ic_in     = IC_W'(shifted - (cyc_hi_in ? FIVE_CYCLES : FOUR_CYCLES));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_s1_ff <= t_s1_in;
         pday_ff <= pday_in;
      end
      if (en[1]) begin
         t_s2_ff   <= t_s2_in;
         dsec_ff   <= dsec_in;
         ic_ff     <= ic_in;
         cyc_hi_ff <= cyc_hi_in;
      end
   end

   assign t_s2        = t_s2_ff;
   assign day_secs_s2 = dsec_ff;
   assign ic_s2       = ic_ff;
   assign cyc_hi_s2   = cyc_hi_ff;

endmodule

>>> hw/rtl/e2c_tod.sv
// ----------------------------------------------------------------------------
// e2c_tod
// Time-of-day stages: hour, minute and second from the seconds within the day.
// ----------------------------------------------------------------------------
module e2c_tod
   import e2c_pkg::*;
(
   input  logic               clock,
   input  logic [5:0]         en,
   input  logic [EPOCH_W-1:0] t_s2,
   input  logic [EPOCH_W-1:0] day_secs_s2,
   output logic [HOUR_W-1:0]  hour,
   output logic [MIN_W-1:0]   minute,
   output logic [SEC_W-1:0]   second
);

   logic [SOD_W-1:0]  sod_ff, sod_in;
   logic [26:0]       ph_ff, ph_in;

   logic [HOUR_W-1:0] hr4_ff, hr4_in;
   logic [11:0]       remh4_ff, remh4_in;

   logic [HOUR_W-1:0] hr5_ff;
   logic [11:0]       remh5_ff;
   logic [20:0]       pm_ff, pm_in;

   logic [HOUR_W-1:0] hr6_ff, hr7_ff, hr8_ff;
   logic [MIN_W-1:0]  mn6_ff, mn6_in, mn7_ff, mn8_ff;
   logic [SEC_W-1:0]  sc6_ff, sc6_in, sc7_ff, sc8_ff;

   always_comb begin
      sod_in = SOD_W'(t_s2 - day_secs_s2);
      ph_in  = 27'(sod_in[16:4]) * 27'(RCP_HOUR);
   end

   always_comb begin
      hr4_in   = HOUR_W'(ph_ff >> SH_HOUR);
      remh4_in = 12'(sod_ff - SOD_W'(SOD_W'(hr4_in) * SOD_W'(3600)));
   end

   assign pm_in = 21'(remh4_ff[11:2]) * 21'(RCP_MIN);

   always_comb begin
      mn6_in = MIN_W'(pm_ff >> SH_MIN);
      sc6_in = SEC_W'(remh5_ff - 12'(12'(mn6_in) * 12'd60));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sod_ff <= sod_in;
         ph_ff  <= ph_in;
      end
      if (en[1]) begin
         hr4_ff   <= hr4_in;
         remh4_ff <= remh4_in;
      end
      if (en[2]) begin
         hr5_ff   <= hr4_ff;
         remh5_ff <= remh4_ff;
         pm_ff    <= pm_in;
      end
      if (en[3]) begin
         hr6_ff <= hr5_ff;
         mn6_ff <= mn6_in;
         sc6_ff <= sc6_in;
      end
      if (en[4]) begin
         hr7_ff <= hr6_ff;
         mn7_ff <= mn6_ff;
         sc7_ff <= sc6_ff;
      end
      if (en[5]) begin
         hr8_ff <= hr7_ff;
         mn8_ff <= mn7_ff;
         sc8_ff <= sc7_ff;
      end
   end

   assign hour   = hr8_ff;
   assign minute = mn8_ff;
   assign second = sc8_ff;

endmodule

>>> hw/rtl/e2c_date.sv
// ----------------------------------------------------------------------------
// e2c_date
// Calendar stages: year of era, day of year, month and day from the day
// within the 400-year cycle.
// ----------------------------------------------------------------------------
module e2c_date
   import e2c_pkg::*;
(
   input  logic               clock,
   input  logic [5:0]         en,
   input  logic [IC_W-1:0]    ic_s2,
   input  logic               cyc_hi_s2,
   output logic [YEAR_W-1:0]  year,
   output logic [MONTH_W-1:0] month,
   output logic [DOM_W-1:0]   day_of_month
);

   logic [IC_W-1:0]   ic3_ff, ic4_ff, ic5_ff;
   logic              hi3_ff, hi4_ff, hi5_ff, hi6_ff, hi7_ff;
   logic [32:0]       pq_ff, pq_in;
   logic [2:0]        cen_ff, cen_in;
   logic              last_ff, last_in;

   logic [IC_W-1:0]   num_ff, num_in;
   logic [6:0]        quads;

   logic [36:0]       py_ff, py_in;

   logic [YOE_W-1:0]  yoe_in, yoe6_ff, yoe7_ff;
   logic [1:0]        c100;
   logic [DOY_W-1:0]  doy6_ff, doy6_in, doy7_ff;

   logic [10:0]       mpn;
   logic [22:0]       pmp_ff, pmp_in;

   logic [MP_W-1:0]   mp;
   logic [MONTH_W-1:0] mon_in;
   logic [YEAR_W-1:0] yr_in;
   logic [DOM_W-1:0]  dom_in;
   logic [YEAR_W-1:0] yr_ff;
   logic [MONTH_W-1:0] mon_ff;
   logic [DOM_W-1:0]  dom_ff;

   always_comb begin
      pq_in   = 33'(ic_s2[17:2]) * 33'(RCP_QUAD);
      cen_in  = 3'(ic_s2 >= CENTURY_1) + 3'(ic_s2 >= CENTURY_2) +
                3'(ic_s2 >= CENTURY_3) + 3'(ic_s2 >= LAST_DAY_CYCLE);
      last_in = (ic_s2 == LAST_DAY_CYCLE);
   end

   always_comb begin
      quads  = 7'(pq_ff >> SH_QUAD);
      num_in = IC_W'(ic3_ff - IC_W'(quads) + IC_W'(cen_ff) - IC_W'(last_ff));
   end

   assign py_in = 37'(num_ff) * 37'(RCP_YEAR);

   always_comb begin
      yoe_in  = YOE_W'(py_ff >> SH_YEAR);
      c100    = 2'(yoe_in >= 9'd100) + 2'(yoe_in >= 9'd200) + 2'(yoe_in >= 9'd300);
      doy6_in = DOY_W'(ic5_ff - (IC_W'(IC_W'(yoe_in) * IC_W'(365)) +
                                 IC_W'(yoe_in >> 2) - IC_W'(c100)));
   end

   always_comb begin
      mpn    = 11'(11'(doy6_ff) * 11'd5 + 11'd2);
      pmp_in = 23'(mpn) * 23'(RCP_MONTH);
   end

   always_comb begin
      mp     = MP_W'(pmp_ff >> SH_MONTH);
      dom_in = DOM_W'(doy7_ff - month_start(mp) + 9'd1);
      mon_in = (mp < 4'd10) ? MONTH_W'(mp + 4'd3) : MONTH_W'(mp - 4'd9);
      yr_in  = YEAR_W'(yoe7_ff) + (hi7_ff ? 12'd2000 : 12'd1600) +
               12'(mon_in <= 4'd2);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ic3_ff  <= ic_s2;
         hi3_ff  <= cyc_hi_s2;
         pq_ff   <= pq_in;
         cen_ff  <= cen_in;
         last_ff <= last_in;
      end
      if (en[1]) begin
         ic4_ff <= ic3_ff;
         hi4_ff <= hi3_ff;
         num_ff <= num_in;
      end
      if (en[2]) begin
         ic5_ff <= ic4_ff;
         hi5_ff <= hi4_ff;
         py_ff  <= py_in;
      end
      if (en[3]) begin
         hi6_ff  <= hi5_ff;
         yoe6_ff <= yoe_in;
         doy6_ff <= doy6_in;
      end
      if (en[4]) begin
         hi7_ff  <= hi6_ff;
         yoe7_ff <= yoe6_ff;
         doy7_ff <= doy6_ff;
         pmp_ff  <= pmp_in;
      end
      if (en[5]) begin
         yr_ff  <= yr_in;
         mon_ff <= mon_in;
         dom_ff <= dom_in;
      end
   end

   assign year         = yr_ff;
   assign month        = mon_ff;
   assign day_of_month = dom_ff;

endmodule

>>> hw/rtl/epoch_to_civil_datetime.sv
// ----------------------------------------------------------------------------
// epoch_to_civil_datetime
// Converts a 32-bit count of UTC seconds since 1970-01-01 into a Gregorian
// date and time of day.
// ----------------------------------------------------------------------------
// A word on the req_ channel carries one unsigned seconds count. For every
// accepted word the rsp_ channel returns exactly one word with year, month,
// day of month, hour, minute and second, in the order the requests came in.
// Both channels use a valid/ready handshake.
// The datapath is an eight-stage pipeline, one constant multiplication or
// comparable step per stage. A new word is accepted every cycle unless a
// stall from the receiver has filled every stage.
// When the receiver stalls, the last stage holds its word and earlier stages
// keep moving until they meet an occupied stage, so empty slots fill up before
// req_ready drops. Nothing is lost or repeated across a stall.
// Reset clears all stage valid bits; the block is ready in the cycle after
// reset is released. The conversion keeps no other state.
// ----------------------------------------------------------------------------
module epoch_to_civil_datetime
   import e2c_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [EPOCH_W-1:0] req_epoch_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [YEAR_W-1:0]  rsp_year,
   output logic [MONTH_W-1:0] rsp_month,
   output logic [DOM_W-1:0]   rsp_day_of_month,
   output logic [HOUR_W-1:0]  rsp_hour,
   output logic [MIN_W-1:0]   rsp_minute,
   output logic [SEC_W-1:0]   rsp_second
);

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] en;

   logic [EPOCH_W-1:0]    t_s2;
   logic [EPOCH_W-1:0]    day_secs_s2;
   logic [IC_W-1:0]       ic_s2;
   logic                  cyc_hi_s2;

   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         en[s] = !vld_ff[s] || en[s+1];
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (en[s]) begin
            vld_in[s] = (s == 0) ? req_valid : vld_ff[(s == 0) ? 0 : s - 1];
         end else begin
            vld_in[s] = vld_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   e2c_front u_front (
      .clock         (clock),
      .en            (en[1:0]),
      .epoch_seconds (req_epoch_seconds),
      .t_s2          (t_s2),
      .day_secs_s2   (day_secs_s2),
      .ic_s2         (ic_s2),
      .cyc_hi_s2     (cyc_hi_s2)
   );

   e2c_tod u_tod (
      .clock       (clock),
      .en          (en[7:2]),
      .t_s2        (t_s2),
      .day_secs_s2 (day_secs_s2),
      .hour        (rsp_hour),
      .minute      (rsp_minute),
      .second      (rsp_second)
   );

   e2c_date u_date (
      .clock        (clock),
      .en           (en[7:2]),
      .ic_s2        (ic_s2),
      .cyc_hi_s2    (cyc_hi_s2),
      .year         (rsp_year),
      .month        (rsp_month),
      .day_of_month (rsp_day_of_month)
   );

   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (vld_ff[0] && !en[1]))
      else $error("req_ready low while the first stage could move");

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ($countones(vld_ff) == NUM_STAGES))
      else $error("input blocked with an empty stage in the pipeline");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 &&
                     rsp_day_of_month != 5'd0))
      else $error("month or day of month out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("time of day out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_year >= 12'd1970 && rsp_year <= 12'd2106))
      else $error("year out of range");

endmodule

>>> tb/epoch_to_civil_datetime_tb.sv
// ----------------------------------------------------------------------------
// epoch_to_civil_datetime_tb
// Checks the seconds-to-calendar converter against its own date arithmetic.
// ----------------------------------------------------------------------------
// Seconds counts go in on the req_ channel. Directed corner values come first,
// then random words that favor day edges and both ends of the range. A
// scoreboard works out the calendar date and time of day for every accepted
// word and compares each returned word with the oldest one still waiting.
// Both sides pause at random, except during one long calm stretch.
// ----------------------------------------------------------------------------
module epoch_to_civil_datetime_tb
   import e2c_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM = 1750;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT = 13;
   localparam int CALM_FIRST = 700;
   localparam int CALM_LAST = 1000;
   localparam int SECS_IN_DAY = 86400;
   localparam int LAST_FULL_DAY = 49709;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DOM_W-1:0]   day_of_month;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
   } civil_time_type;

   class civil_time_scoreboard;
      civil_time_type expected_dates[$];
      int             fail_count = 0;

      static function civil_time_type civil_of_epoch(input logic [EPOCH_W-1:0] secs);
         int unsigned day_count, day_secs, shifted, era, day_of_era;
         int unsigned year_of_era, day_of_year, march_month, cal_month;
         civil_time_type r;
         day_count   = secs / 86400;
         day_secs    = secs % 86400;
         shifted     = day_count + 719468;
         era         = shifted / 146097;
         day_of_era  = shifted - era * 146097;
         year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                        - day_of_era / 146096) / 365;
         day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4
                                     - year_of_era / 100);
         march_month = (5 * day_of_year + 2) / 153;
         cal_month   = (march_month < 10) ? march_month + 3 : march_month - 9;
         r.year         = YEAR_W'(year_of_era + era * 400 + ((cal_month <= 2) ? 1 : 0));
         r.month        = MONTH_W'(cal_month);
         r.day_of_month = DOM_W'(day_of_year - (153 * march_month + 2) / 5 + 1);
         r.hour         = HOUR_W'(day_secs / 3600);
         r.minute       = MIN_W'((day_secs % 3600) / 60);
         r.second       = SEC_W'(day_secs % 60);
         return r;
      endfunction

      function void note_request(input logic [EPOCH_W-1:0] secs);
         expected_dates.push_back(civil_of_epoch(secs));
      endfunction

      function void check_response(input civil_time_type got);
         civil_time_type want;
         if (expected_dates.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected word: %0d-%0d-%0d %0d:%0d:%0d", got.year,
                        got.month, got.day_of_month, got.hour, got.minute,
                        got.second);
            return;
         end
         want = expected_dates.pop_front();
         if (got.year !== want.year || got.month !== want.month
             || got.day_of_month !== want.day_of_month || got.hour !== want.hour
             || got.minute !== want.minute || got.second !== want.second) begin
            fail_count++;
            if (fail_count <= 10)
               $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                        want.year, want.month, want.day_of_month, want.hour,
                        want.minute, want.second, got.year, got.month,
                        got.day_of_month, got.hour, got.minute, got.second);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [EPOCH_W-1:0] req_epoch_seconds;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [YEAR_W-1:0]  rsp_year;
   logic [MONTH_W-1:0] rsp_month;
   logic [DOM_W-1:0]   rsp_day_of_month;
   logic [HOUR_W-1:0]  rsp_hour;
   logic [MIN_W-1:0]   rsp_minute;
   logic [SEC_W-1:0]   rsp_second;

   bit                   calm = 1'b0;
   int                   cycle_count;
   civil_time_scoreboard date_board = new();

   logic [EPOCH_W-1:0] corner_secs [19] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd68169600, 32'd946684799, 32'd951782400, 32'd951868800,
      32'd4107542399, 32'd4107542400, 32'd2147483647, 32'd2147483648,
      32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF
   };

   epoch_to_civil_datetime i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_word(input logic [EPOCH_W-1:0] secs);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_epoch_seconds = secs;
      do @(posedge clock); while (!req_ready);
      date_board.note_request(secs);
   endtask

   function automatic logic [EPOCH_W-1:0] random_secs();
      logic [EPOCH_W-1:0] day_start;
      day_start = EPOCH_W'($urandom_range(LAST_FULL_DAY) * SECS_IN_DAY);
      case ($urandom_range(4))
         0:       return day_start;
         1:       return day_start + EPOCH_W'(SECS_IN_DAY - 1 - $urandom_range(3));
         2:       return 32'hFFFFFFFF - EPOCH_W'($urandom_range(200000));
         3:       return EPOCH_W'($urandom_range(200000));
         default: return $urandom();
      endcase
   endfunction

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         date_board.check_response('{rsp_year, rsp_month, rsp_day_of_month,
                                     rsp_hour, rsp_minute, rsp_second});
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_epoch_seconds = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (corner_secs[i])
         send_word(corner_secs[i]);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         calm = (n >= CALM_FIRST && n < CALM_LAST);
         send_word(random_secs());
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid = 1'b0;

      while (date_board.expected_dates.size() != 0)
         @(posedge clock);
      repeat (3 * NUM_STAGES) @(posedge clock);

      if (date_board.fail_count == 0 && date_board.expected_dates.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/e2c_pkg.sv
hw/rtl/e2c_front.sv
hw/rtl/e2c_tod.sv
hw/rtl/e2c_date.sv
hw/rtl/epoch_to_civil_datetime.sv
tb/epoch_to_civil_datetime_tb.sv
